### rtl/arp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the arp address table
// depends on nothing; imported by arp_store and arp_address_table
package arp_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IP_BYTES    = 4;
  localparam int MAC_BYTES   = 6;
  localparam int KEY_W       = 8 * IP_BYTES;
  localparam int MAC_W       = 8 * MAC_BYTES;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W       = 4;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  // operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_UPDATE = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // write request into the binding store
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [KEY_W-1:0] key;
    logic [MAC_W-1:0] mac;
  } wr_req_t;

endpackage

### rtl/arp_store.sv
`timescale 1ns / 1ps
// binding store: key and mac memories, one write port, one registered read port
// depends on arp_pkg
module arp_store (
  input  logic                       clk,
  input  arp_pkg::wr_req_t           wr_req,
  input  logic [arp_pkg::IDX_W-1:0]  rd_addr,
  output logic [arp_pkg::KEY_W-1:0]  rd_key,
  output logic [arp_pkg::MAC_W-1:0]  rd_mac
);
  import arp_pkg::*;

  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [MAC_W-1:0] mac_mem [TABLE_DEPTH];
  logic [KEY_W-1:0] rd_key_r;
  logic [MAC_W-1:0] rd_mac_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      key_mem[wr_req.addr] <= wr_req.key;
      mac_mem[wr_req.addr] <= wr_req.mac;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_key_r <= key_mem[rd_addr];
    rd_mac_r <= mac_mem[rd_addr];
  end

  assign rd_key = rd_key_r;
  assign rd_mac = rd_mac_r;

endmodule

### rtl/arp_address_table.sv
`timescale 1ns / 1ps
// arp address table top level: command sequencer around the binding store
// depends on arp_pkg and arp_store
//
// Ordered table of up to 16 IPv4-to-MAC bindings. A command beat is taken when
// start is high and busy is low; exactly one result beat follows, shown for one
// cycle with out_valid, and the receiver cannot stall it. Insert, and any other
// operation on an empty table, answers in the cycle after start. Lookup, update
// and remove walk the list one entry per cycle through the single read port of
// the store: a hit answers once its entry is compared, a miss once the last
// entry has been compared. Remove then closes the gap by copying one entry per
// cycle. busy stays high until the result beat.
module arp_address_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_op,
  input  logic [arp_pkg::KEY_W-1:0]  in_key_ip,
  input  logic [arp_pkg::MAC_W-1:0]  in_mac_in,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [arp_pkg::POS_W-1:0]  out_position,
  output logic [arp_pkg::MAC_W-1:0]  out_mac_out
);
  import arp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [MAC_W-1:0] mac_r, mac_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] wr_r, wr_nxt;
  logic [IDX_W-1:0] hit_r, hit_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [MAC_W-1:0] out_mac_r, out_mac_nxt;

  wr_req_t          wr_req;
  logic [IDX_W-1:0] rd_addr;
  logic [KEY_W-1:0] rd_key;
  logic [MAC_W-1:0] rd_mac;
  logic             accept;
  logic [IDX_W-1:0] cmp_idx;
  logic             key_hit;

  arp_store u_store (
    .clk     (clk),
    .wr_req  (wr_req),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_mac  (rd_mac)
  );

  assign accept  = start && (state_r == S_IDLE);
  // index of the entry whose data sits on the read port
  assign cmp_idx = IDX_W'(idx_r - CNT_W'(1));
  assign key_hit = pend_r && (rd_key == key_r);

  // sequencer next-state logic
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    mac_nxt        = mac_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    wr_nxt         = wr_r;
    hit_nxt        = hit_r;
    pend_nxt       = 1'b0;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_mac_nxt    = out_mac_r;
    rd_addr        = idx_r[IDX_W-1:0];
    wr_req         = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt  = op_t'(in_op);
          key_nxt = in_key_ip;
          mac_nxt = in_mac_in;
          idx_nxt = '0;
          if (op_t'(in_op) == OP_INSERT) begin
            // append at the tail or report full
            out_valid_nxt = 1'b1;
            out_mac_nxt   = '0;
            if (count_r == DEPTH_CNT) begin
              out_status_nxt = ST_FULL;
              out_pos_nxt    = '0;
            end else begin
              wr_req.en      = 1'b1;
              wr_req.addr    = count_r[IDX_W-1:0];
              wr_req.key     = in_key_ip;
              wr_req.mac     = in_mac_in;
              out_status_nxt = ST_DONE;
              out_pos_nxt    = POS_W'(count_r);
              count_nxt      = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            // nothing to search
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_MISSING;
            out_pos_nxt    = '0;
            out_mac_nxt    = '0;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (key_hit) begin
          hit_nxt = cmp_idx;
          case (op_r)
            OP_REMOVE: begin
              // copy later entries forward, reading from hit + 1
              state_nxt = S_SHIFT;
              wr_nxt    = cmp_idx;
            end
            OP_UPDATE: begin
              wr_req.en      = 1'b1;
              wr_req.addr    = cmp_idx;
              wr_req.key     = key_r;
              wr_req.mac     = mac_r;
              state_nxt      = S_IDLE;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_DONE;
              out_pos_nxt    = POS_W'(cmp_idx);
              out_mac_nxt    = '0;
            end
            default: begin
              state_nxt      = S_IDLE;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_DONE;
              out_pos_nxt    = POS_W'(cmp_idx);
              out_mac_nxt    = (op_r == OP_LOOKUP) ? rd_mac : '0;
            end
          endcase
        end else if (pend_r && idx_r == count_r) begin
          // last valid entry compared without a match
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_MISSING;
          out_pos_nxt    = '0;
          out_mac_nxt    = '0;
        end else begin
          idx_nxt  = idx_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end
      end
      S_SHIFT: begin
        if (pend_r) begin
          wr_req.en   = 1'b1;
          wr_req.addr = wr_r;
          wr_req.key  = rd_key;
          wr_req.mac  = rd_mac;
          wr_nxt      = wr_r + IDX_W'(1);
        end
        if (idx_r < count_r) begin
          idx_nxt  = idx_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end else begin
          state_nxt      = S_IDLE;
          count_nxt      = count_r - CNT_W'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DONE;
          out_pos_nxt    = POS_W'(hit_r);
          out_mac_nxt    = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (!accept && state_r == S_IDLE) begin
      pend_nxt = 1'b0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
      op_r         <= op_nxt;
      key_r        <= key_nxt;
      mac_r        <= mac_nxt;
      idx_r        <= idx_nxt;
      wr_r         <= wr_nxt;
      hit_r        <= hit_nxt;
      out_status_r <= out_status_nxt;
      out_pos_r    <= out_pos_nxt;
      out_mac_r    <= out_mac_nxt;
    end
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_pos_r;
  assign out_mac_out  = out_mac_r;

  // occupancy never passes the table depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("entry count beyond table depth");

  // a result beat only appears once the sequencer is back to idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result beat while still busy");

  // an accepted command either answers at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid_r))
    else $error("command beat dropped");

  // a successful insert grows the table by exactly one entry
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op_t'(in_op) == OP_INSERT && count_r != DEPTH_CNT)
      |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the table");

endmodule

### tb/sv/tb_arp_address_table.sv
`timescale 1ns / 1ps
// self-checking testbench for arp_address_table: directed and random command beats
// depends on arp_pkg and the arp_address_table rtl; holds its own binding list model
module tb_arp_address_table;
  import arp_pkg::*;

  // binding list model and expected result store
  class arp_table_scoreboard;
    typedef struct {
      status_t          status;
      logic [POS_W-1:0] position;
      logic [MAC_W-1:0] mac;
    } arp_reply_t;

    logic [KEY_W-1:0] keys [TABLE_DEPTH];
    logic [MAC_W-1:0] macs [TABLE_DEPTH];
    int unsigned      entries;
    arp_reply_t       expected_replies [$];
    int unsigned      mismatches;

    function new();
      entries    = 0;
      mismatches = 0;
    endfunction

    // apply one accepted command beat to the list and queue its reply
    function void note_command(op_t op, logic [KEY_W-1:0] key, logic [MAC_W-1:0] mac);
      arp_reply_t reply;
      int         hit;
      reply.status   = ST_DONE;
      reply.position = '0;
      reply.mac      = '0;
      hit            = -1;
      if (op == OP_INSERT) begin
        if (entries >= TABLE_DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          keys[entries]  = key;
          macs[entries]  = mac;
          reply.position = POS_W'(entries);
          entries++;
        end
      end else begin
        // first match in list order
        for (int i = 0; i < entries; i++) begin
          if (hit < 0 && keys[i] == key) hit = i;
        end
        if (hit < 0) begin
          reply.status = ST_MISSING;
        end else begin
          reply.position = POS_W'(hit);
          case (op)
            OP_REMOVE: begin
              for (int i = hit; i + 1 < entries; i++) begin
                keys[i] = keys[i+1];
                macs[i] = macs[i+1];
              end
              entries--;
            end
            OP_LOOKUP: begin
              reply.mac = macs[hit];
            end
            default: begin
              macs[hit] = mac;
            end
          endcase
        end
      end
      expected_replies.push_back(reply);
    endfunction

    // compare one result beat with the oldest expected reply
    function void check_result(logic [1:0] status, logic [POS_W-1:0] position,
                               logic [MAC_W-1:0] mac);
      arp_reply_t want;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: status %0d pos %0d mac %h", status, position, mac);
        return;
      end
      want = expected_replies.pop_front();
      if (status !== 2'(want.status) || position !== want.position || mac !== want.mac) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d pos %0d mac %h, got status %0d pos %0d mac %h",
                   want.status, want.position, want.mac, status, position, mac);
      end
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    function int unsigned live_count();
      return entries;
    endfunction

    // key of a random binding now in the list
    function logic [KEY_W-1:0] live_key();
      return keys[$urandom_range(0, entries - 1)];
    endfunction
  endclass

  logic             clk;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       in_op = 2'd0;
  logic [KEY_W-1:0] in_key_ip = '0;
  logic [MAC_W-1:0] in_mac_in = '0;
  logic             out_valid;
  logic [1:0]       out_status;
  logic [POS_W-1:0] out_position;
  logic [MAC_W-1:0] out_mac_out;

  arp_table_scoreboard sb = new();
  logic [KEY_W-1:0]    key_pool [8];
  int unsigned         commands_sent = 0;
  bit                  idle_gaps = 1'b1;

  arp_address_table DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_key_ip    (in_key_ip),
    .in_mac_in    (in_mac_in),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_position (out_position),
    .out_mac_out  (out_mac_out)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result beat monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_status, out_position, out_mac_out);
  end

  // overall time limit
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    return MAC_W'({$urandom(), $urandom()});
  endfunction

  // mostly keys already bound, some from a small pool for duplicates, some noise
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65 && sb.live_count() > 0) return sb.live_key();
    if (r < 85) return key_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  // drive one command beat; start is left high after acceptance
  task automatic send(input op_t op, input logic [KEY_W-1:0] key, input logic [MAC_W-1:0] mac);
    int gap;
    gap = idle_gaps ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_op     <= op;
    in_key_ip <= key;
    in_mac_in <= mac;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(op, key, mac);
    commands_sent++;
  endtask

  // hold off until every expected result beat has come
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // one random sequence: fill to full, drain to empty, or a mix
  task automatic run_episode();
    int   kind;
    int   len;
    int   r;
    op_t  op;
    idle_gaps = ($urandom_range(0, 3) != 0);
    kind      = $urandom_range(0, 3);
    case (kind)
      0: begin
        while (sb.live_count() < TABLE_DEPTH) send(OP_INSERT, pick_key(), rand_mac());
        repeat ($urandom_range(1, 3)) send(OP_INSERT, pick_key(), rand_mac());
        send(OP_LOOKUP, pick_key(), rand_mac());
      end
      1: begin
        while (sb.live_count() > 0) begin
          if ($urandom_range(0, 9) == 0) send(OP_REMOVE, $urandom(), rand_mac());
          else send(OP_REMOVE, sb.live_key(), rand_mac());
        end
        send(op_t'($urandom_range(1, 3)), pick_key(), rand_mac());
      end
      default: begin
        len = $urandom_range(10, 40);
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (sb.live_count() == 0 && r < 60) op = OP_INSERT;
          else if (r < 30) op = OP_INSERT;
          else if (r < 50) op = OP_REMOVE;
          else if (r < 75) op = OP_LOOKUP;
          else op = OP_UPDATE;
          send(op, pick_key(), rand_mac());
        end
      end
    endcase
    if ($urandom_range(0, 7) == 0) wait_drained();
  endtask

  // stimulus and end of run
  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 8; i++) key_pool[i] = $urandom();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty table misses
    send(OP_LOOKUP, 32'h0000_0000, '0);
    send(OP_REMOVE, 32'hffff_ffff, '1);
    send(OP_UPDATE, 32'h0000_0000, '1);
    // extreme keys and macs, duplicate key
    send(OP_INSERT, 32'h0000_0000, '0);
    send(OP_INSERT, 32'hffff_ffff, '1);
    send(OP_INSERT, 32'hffff_ffff, 48'h0123_4567_89ab);
    send(OP_LOOKUP, 32'hffff_ffff, '0);
    send(OP_UPDATE, 32'hffff_ffff, 48'ha5a5_5a5a_a5a5);
    send(OP_LOOKUP, 32'hffff_ffff, '1);
    // remove first of the duplicates, the second moves up
    send(OP_REMOVE, 32'hffff_ffff, '0);
    send(OP_LOOKUP, 32'hffff_ffff, '0);
    send(OP_REMOVE, 32'h0000_0000, '0);
    send(OP_LOOKUP, 32'h0000_0001, '0);
    wait_drained();

    while (commands_sent < 13 + 1050) run_episode();
    start <= 1'b0;

    // let the last result beats come in
    for (int w = 0; w < 4000 && sb.pending() != 0; w++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.pending() != 0) $display("%0d result beats never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/arp_pkg.sv
rtl/arp_store.sv
rtl/arp_address_table.sv
tb/sv/tb_arp_address_table.sv
